[src/mvc_pkg.sv]
`default_nettype none
package mvc_pkg;
  localparam int unsigned MaxVertices = 32;
  localparam logic [1:0] MarkFree = 2'd0;
  localparam logic [1:0] MarkIn   = 2'd1;
  localparam logic [1:0] MarkOut  = 2'd2;
  localparam logic [5:0] CountReset = 6'd32;
endpackage
`default_nettype wire

[src/min_vertex_cover_search_unit.sv]
// channel   | dir | payload
// s_axis    | in  | tdata {row_bits, row_index}, tlast last_row
// m_axis    | out | tdata cover_size
// cfg       | in  | vertex_count
// rows load one per cycle into the adjacency memory while idle, also while a result waits.
// a last row starts the search, which pushes, pops, switches to the
// exclusion branch and finally hands out the result.
// a leaf check reads each row from memory, then compares it.
// reset clears marks and control; rows are undefined until written.
// the result waits in an output register; input stalls while searching.
`default_nettype none
module min_vertex_cover_search_unit
  import mvc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVertices
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // row_index[4:0], row_bits[36:5], zero
  input  wire logic        s_axis_tlast,  // last_row
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // cover_size[5:0], zero
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [5:0]  cfg_data_i
);
  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [2:0] SIdle = 3'd0, SCall = 3'd1, SRet = 3'd2,
                         SExcl = 3'd3, SLeaf = 3'd4, SLeafChk = 3'd5, SDone = 3'd6,
                         SExclSet = 3'd7;

  logic [31:0] adj_mem [MAX_VERTICES];
  logic [31:0] adj_rd_q;
  logic [IW-1:0] adj_addr;
  logic [IW-1:0] tgt_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fm_mem [MAX_VERTICES];
  logic [CW-1:0] fs_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] ph_q;
  logic [MAX_VERTICES-1:0] in_q, out_q;
  logic [2:0] st_q;
  logic [5:0] vc_q;
  logic [CW-1:0] n_q, best_q, size_q, start_q, lvl_q, leaf_i_q;
  logic [IW-1:0] t_q;
  logic [7:0] res_q;
  logic res_v_q;

  assign s_axis_tready = (st_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata = res_q;

  wire acc = s_axis_tvalid && s_axis_tready;
  wire [4:0] row_idx = s_axis_tdata[4:0];
  // output register free now or emptied at this edge
  wire res_free = !res_v_q || m_axis_tready;

  // lowest free vertex at or after start_q
  logic found;
  logic [IW-1:0] fv;
  always_comb begin
    found = 1'b0;
    fv = '0;
    for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
      if (v < n_q && v >= start_q && !in_q[v] && !out_q[v]) begin
        found = 1'b1;
        fv = IW'(v);
      end
    end
  end

  // exclusion of t: neighbours within n
  logic [MAX_VERTICES-1:0] nb, vmask;
  logic [CW-1:0] fcnt;
  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      vmask[v] = (v < n_q);
      nb[v] = (v < 32) ? adj_rd_q[v] : 1'b0;
    end
    nb = nb & vmask;
  end
  wire [MAX_VERTICES-1:0] forced = nb & ~in_q & ~out_q & ~(MAX_VERTICES'(1) << t_q);
  wire conflict = |(nb & out_q) | nb[t_q];
  always_comb begin
    fcnt = '0;
    for (int v = 0; v < MAX_VERTICES; v++) fcnt = fcnt + CW'(forced[v]);
  end

  wire [CW-1:0] lv = lvl_q - CW'(1);
  always_comb begin
    adj_addr = t_q;
    if (st_q == SLeaf) adj_addr = leaf_i_q[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc && (32'(row_idx) < MAX_VERTICES)) adj_mem[row_idx[IW-1:0]] <= s_axis_tdata[36:5];
    adj_rd_q <= adj_mem[adj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SCall && size_q < best_q && found) begin
      tgt_mem[lvl_q[IW-1:0]] <= fv;
      fs_mem[lvl_q[IW-1:0]] <= size_q;
      fm_mem[lvl_q[IW-1:0]] <= '0;
    end
    if (st_q == SExclSet) fm_mem[lv[IW-1:0]] <= conflict ? '0 : forced;
  end

  wire [MAX_VERTICES-1:0] hi_mask = ~((MAX_VERTICES'(2) << leaf_i_q[IW-1:0]) - 1'b1);
  wire leaf_bad = !in_q[leaf_i_q[IW-1:0]] && |(nb & hi_mask & ~in_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; vc_q <= CountReset; res_v_q <= 1'b0; in_q <= '0; out_q <= '0;
      ph_q <= '0; lvl_q <= '0; n_q <= '0; best_q <= '0; size_q <= '0;
      start_q <= '0; t_q <= '0; leaf_i_q <= '0; res_q <= '0;
    end else begin
      if (cfg_valid_i) vc_q <= cfg_data_i;
      res_v_q <= ((st_q == SDone) && res_free) || (res_v_q && !m_axis_tready);
      unique case (st_q)
        SIdle: if (acc && s_axis_tlast) begin
          n_q <= (32'(vc_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vc_q);
          best_q <= (32'(vc_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vc_q);
          in_q <= '0; out_q <= '0; lvl_q <= '0; size_q <= '0; start_q <= '0;
          st_q <= SCall;
        end
        SCall: begin
          if (size_q >= best_q) st_q <= SRet;
          else if (found) begin
            ph_q[lvl_q[IW-1:0]] <= 1'b0;
            lvl_q <= lvl_q + CW'(1);
            in_q[fv] <= 1'b1;
            start_q <= CW'(fv) + CW'(1);
            size_q <= size_q + CW'(1);
          end else begin
            leaf_i_q <= '0; st_q <= SLeaf;
          end
        end
        SLeaf: st_q <= SLeafChk;
        SLeafChk: begin
          if (leaf_bad) st_q <= SRet;
          else if (leaf_i_q + CW'(1) >= n_q) begin
            if (size_q < best_q) best_q <= size_q;
            st_q <= SRet;
          end else begin
            leaf_i_q <= leaf_i_q + CW'(1); st_q <= SLeaf;
          end
        end
        SRet: begin
          if (lvl_q == '0) st_q <= SDone;
          else begin
            t_q <= tgt_mem[lv[IW-1:0]];
            if (!ph_q[lv[IW-1:0]]) st_q <= SExcl;
            else begin
              in_q <= in_q & ~fm_mem[lv[IW-1:0]] & ~(MAX_VERTICES'(1) << tgt_mem[lv[IW-1:0]]);
              out_q <= out_q & ~(MAX_VERTICES'(1) << tgt_mem[lv[IW-1:0]]);
              lvl_q <= lv;
            end
          end
        end
        // adjacency row of t is read during this cycle
        SExcl: st_q <= SExclSet;
        SExclSet: begin
          ph_q[lv[IW-1:0]] <= 1'b1;
          if (conflict) begin
            in_q[t_q] <= 1'b0;
            lvl_q <= lv;
            st_q <= SRet;
          end else begin
            in_q <= (in_q & ~(MAX_VERTICES'(1) << t_q)) | forced;
            out_q[t_q] <= 1'b1;
            start_q <= CW'(t_q) + CW'(1);
            size_q <= fs_mem[lv[IW-1:0]] + fcnt;
            st_q <= SCall;
          end
        end
        SDone: begin
          if (res_free) begin
            res_q <= 8'(best_q); st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
